>>> rtl/chd_pkg.sv
// chd_pkg: shared types, op codes and helpers for the context huffman decoder
// no dependencies; used by chd_front, chd_back and the top level
package chd_pkg;

    localparam int LVL_W      = 3;
    localparam int CTX_W      = 56;
    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;
    localparam int BYTE_BITS  = 8;
    localparam int HIST_DEPTH = 7;
    localparam int NUM_LVL    = 8;
    localparam int OP_W       = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    localparam logic KIND_SYM = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [CTX_W-1:0]  context_bytes;
        logic [LVL_W-1:0]  level;
    } t_entry;

    typedef struct packed {
        logic [BYTE_BITS-1:0] code_byte;
        t_entry               entry;
        logic [OP_W-1:0]      op;
    } t_cmd;

    // low 8*level bits set
    function automatic logic [CTX_W-1:0] ctx_mask(input logic [LVL_W-1:0] level);
        logic [CTX_W-1:0] m;
        m = '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            if (LVL_W'(i) < level) begin
                m[i*BYTE_BITS +: BYTE_BITS] = '1;
            end
        end
        return m;
    endfunction

    // low len bits set
    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int i = 0; i < CODE_W; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

endpackage

>>> rtl/chd_front.sv
// chd_front: accepts input items, drops unused op codes, queues commands
// depends on chd_pkg
module chd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  chd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_cmd_valid,
    output chd_pkg::t_cmd o_cmd
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    chd_pkg::t_cmd    r_q [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             w_push, w_pop;

    // op 3 means nothing: taken but not queued
    assign w_push = i_accept && (i_cmd.op == chd_pkg::OP_LOAD ||
                                 i_cmd.op == chd_pkg::OP_DECODE ||
                                 i_cmd.op == chd_pkg::OP_END);
    assign w_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

    assign o_full      = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

endmodule

>>> rtl/chd_back.sv
// chd_back: code table memory, per-bit table scan, history and result output
// depends on chd_pkg
module chd_back #(
    parameter int TABLE_ENTRIES = 512,
    parameter int MAX_CODE_BITS = 32,
    parameter int MAX_CONTEXT   = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  chd_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [chd_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BIT    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    chd_pkg::t_entry r_mem [TABLE_ENTRIES];
    chd_pkg::t_entry r_rd;

    logic [2:0]                        r_state;
    logic [CNT_W-1:0]                  r_cnt, r_issue;
    logic                              r_dv;
    logic [chd_pkg::CTX_W-1:0]         r_hist;
    logic [chd_pkg::LVL_W-1:0]         r_hcnt;
    logic [chd_pkg::CODE_W-1:0]        r_acc;
    logic [chd_pkg::LEN_W-1:0]         r_alen;
    logic [chd_pkg::BYTE_BITS-1:0]     r_byte;
    logic [2:0]                        r_bit;
    logic [chd_pkg::NUM_LVL-1:0]       r_exist, r_cv;
    logic [chd_pkg::SYM_W-1:0]         r_csym [chd_pkg::NUM_LVL];
    logic                              r_pv, r_p_kind;
    logic [chd_pkg::SYM_W-1:0]         r_p_sym;
    logic                              r_ov, r_o_kind, r_o_last;
    logic [chd_pkg::SYM_W-1:0]         r_o_sym;

    logic w_we, w_issue, w_out_free, w_push, w_push_last;
    logic w_lvl_ok, w_ctx_hit, w_code_hit, w_found, w_hit, w_over, w_res;
    logic [chd_pkg::LVL_W-1:0] w_best;

    assign w_out_free = !r_ov || i_ready;
    assign w_we       = (r_state == S_IDLE) && i_cmd_valid &&
                        i_cmd.op == chd_pkg::OP_LOAD && r_cnt < CNT_W'(TABLE_ENTRIES);
    assign w_issue    = (r_state == S_SCAN) && (r_issue < r_cnt);
    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cnt[IDX_W-1:0]] <= i_cmd.entry;
        end
        if (w_issue) begin
            r_rd <= r_mem[r_issue[IDX_W-1:0]];
        end
    end

    // entry compare against current history and accumulator
    assign w_lvl_ok   = ({1'b0, r_rd.level} <= 4'(MAX_CONTEXT)) && (r_hcnt >= r_rd.level);
    assign w_ctx_hit  = ((r_rd.context_bytes ^ r_hist) & chd_pkg::ctx_mask(r_rd.level)) == '0;
    assign w_code_hit = (r_rd.len != '0) && (r_rd.len == r_alen) &&
                        (((r_rd.code ^ r_acc) & chd_pkg::len_mask(r_alen)) == '0);

    always_comb begin
        w_found = 1'b0;
        w_best  = '0;
        for (int l = chd_pkg::NUM_LVL - 1; l >= 0; l--) begin
            if (!w_found && r_exist[l]) begin
                w_found = 1'b1;
                w_best  = chd_pkg::LVL_W'(l);
            end
        end
    end

    assign w_hit  = w_found && r_cv[w_best];
    assign w_over = r_alen >= chd_pkg::LEN_W'(MAX_CODE_BITS);
    assign w_res  = w_hit || w_over;

    // a held result goes out once the next one or the end of the byte is known
    always_comb begin
        w_push      = 1'b0;
        w_push_last = 1'b0;
        if (r_state == S_DECIDE && w_res && r_pv && w_out_free) begin
            w_push = 1'b1;
        end else if (r_state == S_FLUSH && r_pv && w_out_free) begin
            w_push      = 1'b1;
            w_push_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_kind <= r_p_kind;
            r_o_sym  <= r_p_sym;
            r_o_last <= w_push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_issue <= '0;
            r_dv    <= 1'b0;
            r_hist  <= '0;
            r_hcnt  <= '0;
            r_acc   <= '0;
            r_alen  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_exist <= '0;
            r_cv    <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (w_we) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_cmd.op == chd_pkg::OP_END) begin
                            r_hist <= '0;
                            r_hcnt <= '0;
                            r_acc  <= '0;
                            r_alen <= '0;
                        end
                        if (i_cmd.op == chd_pkg::OP_DECODE) begin
                            r_byte  <= i_cmd.code_byte;
                            r_bit   <= 3'd7;
                            r_state <= S_BIT;
                        end
                    end
                end
                S_BIT: begin
                    r_acc   <= {r_acc[chd_pkg::CODE_W-2:0], r_byte[r_bit]};
                    r_alen  <= r_alen + 1'b1;
                    r_exist <= '0;
                    r_cv    <= '0;
                    r_issue <= '0;
                    r_dv    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_dv <= w_issue;
                    if (w_issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (r_dv && w_lvl_ok && w_ctx_hit) begin
                        r_exist[r_rd.level] <= 1'b1;
                        if (w_code_hit && !r_cv[r_rd.level]) begin
                            r_cv[r_rd.level]   <= 1'b1;
                            r_csym[r_rd.level] <= r_rd.symbol;
                        end
                    end
                    if (!r_dv && !w_issue) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!w_res || !r_pv || w_out_free) begin
                        if (w_res) begin
                            r_pv     <= 1'b1;
                            r_acc    <= '0;
                            r_alen   <= '0;
                            r_p_kind <= w_hit ? chd_pkg::KIND_SYM : chd_pkg::KIND_ERR;
                            r_p_sym  <= w_hit ? r_csym[w_best] : '0;
                            if (w_hit) begin
                                r_hist <= {r_hist[chd_pkg::CTX_W-chd_pkg::SYM_W-1:0],
                                           r_csym[w_best]};
                                if (r_hcnt < chd_pkg::LVL_W'(chd_pkg::HIST_DEPTH)) begin
                                    r_hcnt <= r_hcnt + 1'b1;
                                end
                            end
                        end
                        if (r_bit == '0) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_state <= S_BIT;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pv) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ov;
    assign o_kind   = r_o_kind;
    assign o_symbol = r_o_sym;
    assign o_last   = r_o_last;

endmodule

>>> rtl/context_huffman_decoder_unit.sv
// context_huffman_decoder_unit: top level, command queue front and decode back
// depends on chd_pkg, chd_front, chd_back
//
// channel | dir | tdata                                      | tuser | tlast
// s       | in  | level, context, code_bits, code_len,       | op    | -
//         |     | symbol, code_byte                          |       |
// m       | out | symbol                                     | kind  | last
//
// each bit of a code byte scans the table memory once through its
// single registered read port
// reset clears queue, history, accumulator and table fill count
// a four-entry queue lets input keep flowing while the back works or waits
// on the output register
module context_huffman_decoder_unit #(
    parameter int TABLE_ENTRIES = 512,
    parameter int MAX_CODE_BITS = 32,
    parameter int MAX_CONTEXT   = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [119:0] i_s_tdata,  // level, context, code_bits, code_len, symbol, code_byte
    input  logic [1:0]   i_s_tuser,  // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata,  // symbol
    output logic         o_m_tuser,  // kind
    output logic         o_m_tlast
);

    chd_pkg::t_cmd w_in_cmd, w_q_cmd;
    logic          w_full, w_q_valid, w_pop;

    assign w_in_cmd.op                  = i_s_tuser;
    assign w_in_cmd.entry.level         = i_s_tdata[2:0];
    assign w_in_cmd.entry.context_bytes = i_s_tdata[58:3];
    assign w_in_cmd.entry.code          = i_s_tdata[90:59];
    assign w_in_cmd.entry.len           = i_s_tdata[96:91];
    assign w_in_cmd.entry.symbol        = i_s_tdata[104:97];
    assign w_in_cmd.code_byte           = i_s_tdata[112:105];

    assign o_s_tready = !w_full;

    chd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_s_tvalid && o_s_tready),
        .i_cmd       (w_in_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_cmd_valid (w_q_valid),
        .o_cmd       (w_q_cmd)
    );

    chd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .MAX_CONTEXT   (MAX_CONTEXT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (o_m_tuser),
        .o_symbol    (o_m_tdata),
        .o_last      (o_m_tlast)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("error result with non-zero symbol");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !o_s_tready)
        else $error("input taken while queue full");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

endmodule

>>> verif/chd_checker.sv
// chd_checker: watches both stream channels of the decoder, predicts and checks results
// depends on chd_pkg for op codes, result kinds and history depth
module chd_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [119:0] i_s_tdata,  // level, context, code_bits, code_len, symbol, code_byte
    input  logic [1:0]   i_s_tuser,  // op
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [7:0]   i_m_tdata,  // symbol
    input  logic         i_m_tuser,  // kind
    input  logic         i_m_tlast,
    output int           o_pending,
    output int           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_DEPTH = 512;
    localparam int MAX_BITS  = 32;

    typedef struct {
        logic       kind;
        logic [7:0] symbol;
        logic       last;
    } t_decoded;

    t_decoded          decoded_q[$];
    logic [2:0]        tab_level[TAB_DEPTH];
    logic [55:0]       tab_ctx[TAB_DEPTH];
    logic [31:0]       tab_code[TAB_DEPTH];
    logic [5:0]        tab_len[TAB_DEPTH];
    logic [7:0]        tab_sym[TAB_DEPTH];
    int                tab_fill;
    logic [55:0]       history;
    int                hist_cnt;
    logic [31:0]       accum;
    int                accum_len;

    assign o_pending = decoded_q.size();

    // deepest matching context level decides; only that level's codes may hit
    function automatic bit match_codeword(output logic [7:0] sym);
        logic [63:0] cmask;
        logic [63:0] lmask;
        bit          seen;
        sym = '0;
        for (int lv = 7; lv >= 0; lv--) begin
            if (hist_cnt < lv) continue;
            cmask = (64'd1 << (8 * lv)) - 64'd1;
            seen = 0;
            for (int k = 0; k < tab_fill; k++) begin
                if (tab_level[k] == lv && ((tab_ctx[k] ^ history) & cmask[55:0]) == '0) begin
                    seen = 1;
                    break;
                end
            end
            if (!seen) continue;
            for (int k = 0; k < tab_fill; k++) begin
                if (tab_level[k] != lv || ((tab_ctx[k] ^ history) & cmask[55:0]) != '0) continue;
                if (tab_len[k] == 0 || tab_len[k] != accum_len) continue;
                lmask = (64'd1 << tab_len[k]) - 64'd1;
                if ((tab_code[k] & lmask[31:0]) == accum) begin
                    sym = tab_sym[k];
                    return 1;
                end
            end
            return 0;
        end
        return 0;
    endfunction

    task automatic decode_byte(input logic [7:0] cbyte);
        t_decoded   res;
        logic [7:0] sym;
        int         first_new;
        first_new = decoded_q.size();
        for (int b = 7; b >= 0; b--) begin
            accum = {accum[30:0], cbyte[b]};
            accum_len++;
            if (match_codeword(sym)) begin
                history = {history[47:0], sym};
                if (hist_cnt < chd_pkg::HIST_DEPTH) hist_cnt++;
                accum = '0;
                accum_len = 0;
                res = '{chd_pkg::KIND_SYM, sym, 1'b0};
                decoded_q.insert(decoded_q.size(), res);
            end else if (accum_len >= MAX_BITS) begin
                accum = '0;
                accum_len = 0;
                res = '{chd_pkg::KIND_ERR, 8'd0, 1'b0};
                decoded_q.insert(decoded_q.size(), res);
            end
        end
        if (decoded_q.size() > first_new) decoded_q[decoded_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (!i_rst_n) begin
            decoded_q.delete();
            tab_fill  = 0;
            history   = '0;
            hist_cnt  = 0;
            accum     = '0;
            accum_len = 0;
            o_errors  <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    chd_pkg::OP_LOAD: begin
                        if (tab_fill < TAB_DEPTH) begin
                            tab_level[tab_fill] = i_s_tdata[2:0];
                            tab_ctx[tab_fill]   = i_s_tdata[58:3];
                            tab_code[tab_fill]  = i_s_tdata[90:59];
                            tab_len[tab_fill]   = i_s_tdata[96:91];
                            tab_sym[tab_fill]   = i_s_tdata[104:97];
                            tab_fill = tab_fill + 1;
                        end
                    end
                    chd_pkg::OP_DECODE: decode_byte(i_s_tdata[112:105]);
                    chd_pkg::OP_END: begin
                        history   = '0;
                        hist_cnt  = 0;
                        accum     = '0;
                        accum_len = 0;
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tuser, i_m_tdata, i_m_tlast};
                if (decoded_q.size() == 0) begin
                    $error("unexpected item: kind %0d symbol %0h last %0d",
                           got.kind, got.symbol, got.last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d actual %0d", want.kind, got.kind);
                        o_errors <= o_errors + 1;
                    end else if (got.symbol !== want.symbol) begin
                        $error("symbol: expected %0h actual %0h", want.symbol, got.symbol);
                        o_errors <= o_errors + 1;
                    end else if (got.last !== want.last) begin
                        $error("last: expected %0d actual %0d", want.last, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus, handshake idling and verdict for context_huffman_decoder_unit
// depends on chd_pkg, the decoder rtl and chd_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;  // level, context, code_bits, code_len, symbol, code_byte
    logic [1:0]   s_tuser;  // op
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;  // symbol
    logic         m_tuser;  // kind
    logic         m_tlast;
    int           pending;
    int           mismatches;
    int           loads_sent;
    int           idle_cycles;

    context_huffman_decoder_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    chd_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_pending  (pending),
        .o_errors   (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(60, 20);
    endfunction

    // receiver: random gaps, one long hold-off so the input queue backs up
    initial begin
        int k;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        for (int cyc = 0; ; cyc++) begin
            if (cyc == 2000) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            k = gap_len();
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("** context_huffman_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [2:0] lvl,
                             input logic [55:0] ctx, input logic [31:0] code,
                             input logic [5:0] len, input logic [7:0] sym,
                             input logic [7:0] cbyte);
        int k;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, cbyte, sym, len, code, ctx, lvl};
        do @(posedge i_clk); while (!s_tready);
        if (op == chd_pkg::OP_LOAD) loads_sent++;
        k = gap_len();
        if (k > 0) begin
            s_tvalid <= 1'b0;
            repeat (k) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] cbyte);
        send_item(chd_pkg::OP_DECODE, '0, '0, '0, '0, '0, cbyte);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // context made of the last few symbols of a small alphabet
    function automatic logic [55:0] small_ctx(input int lvl);
        logic [55:0] c;
        c = '0;
        for (int i = 0; i < lvl; i++) c[i*8 +: 8] = 8'($urandom_range(5));
        return c;
    endfunction

    initial begin
        int sel;
        int lvl;
        loads_sent = 0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = chd_pkg::OP_LOAD;
        i_rst_n    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // level 0 prefix code, junk above the codeword length
        send_item(chd_pkg::OP_LOAD, 3'd0, 56'hFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE, 6'd1, 8'd1,
                  8'hFF);
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0000_0002, 6'd2, 8'd2, '0);
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0000_0006, 6'd3, 8'd3, '0);
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'hABCD_000E, 6'd4, 8'd0, '0);
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0000_001E, 6'd5, 8'd4, '0);
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0000_001F, 6'd5, 8'hFF, '0);
        // duplicate codeword: first one loaded wins
        send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0000_0000, 6'd1, 8'd9, '0);
        // empty codeword after a 3 stalls until the overlong error
        send_item(chd_pkg::OP_LOAD, 3'd1, 56'hFF_FFFF_FFFF_FF03, 32'hFFFF_FFFF, 6'd0, 8'd7, '0);
        send_item(chd_pkg::OP_LOAD, 3'd1, 56'h00_0000_0000_0002, 32'h0000_0001, 6'd1, 8'd7, '0);
        send_item(chd_pkg::OP_LOAD, 3'd1, 56'h00_0000_0000_0002, 32'h0000_0000, 6'd2, 8'd8, '0);
        // overlong length never matches
        send_item(chd_pkg::OP_LOAD, 3'd7, 56'h01_0101_0101_0101, 32'hFFFF_FFFF, 6'd63, 8'd5, '0);
        send_item(chd_pkg::OP_LOAD, 3'd7, 56'h01_0101_0101_0101, 32'h0000_0001, 6'd33, 8'd6, '0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hB7);
        send_byte(8'hC0);
        repeat (5) send_byte(8'hFF);
        send_byte(8'h00);
        send_item(chd_pkg::OP_END, '1, '1, '1, '1, '1, '1);
        send_item(chd_pkg::OP_RSVD, '1, '1, '1, '1, '1, '1);
        send_byte(8'hAA);
        send_byte(8'h5F);

        for (int n = 0; n < 295; n++) begin
            if (n == 150) drain();
            sel = $urandom_range(99);
            if (sel < 72) begin
                send_byte(8'($urandom));
            end else if (sel < 82) begin
                send_item(chd_pkg::OP_END, 3'($urandom), 56'({$urandom, $urandom}), $urandom,
                          6'($urandom), 8'($urandom), 8'($urandom));
            end else if (sel < 94 && loads_sent < 60) begin
                lvl = $urandom_range(3, 1);
                send_item(chd_pkg::OP_LOAD, 3'(lvl), small_ctx(lvl), $urandom,
                          6'($urandom_range(4, 1)), 8'($urandom_range(5)), 8'($urandom));
            end else if (sel < 96 && loads_sent < 60) begin
                send_item(chd_pkg::OP_LOAD, 3'($urandom), 56'({$urandom, $urandom}), $urandom,
                          6'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_item(chd_pkg::OP_RSVD, 3'($urandom), 56'({$urandom, $urandom}), $urandom,
                          6'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        // late duplicates of an existing codeword lose to the first one loaded
        drain();
        send_item(chd_pkg::OP_END, '0, '0, '0, '0, '0, '0);
        repeat (3) send_item(chd_pkg::OP_LOAD, 3'd0, '0, 32'h0, 6'd1, 8'hEE, '0);
        repeat (6) send_byte(8'($urandom));

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** context_huffman_decoder_unit: PASSED **");
        end else begin
            $display("** context_huffman_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
